>>> src/plru_pkg.sv
// shared constants and controller command type for the lru page replacement block
`timescale 1ns / 1ps
`default_nettype none
package plru_pkg;

   localparam int FRAMES_DEFAULT    = 16;
   localparam int PAGE_BITS_DEFAULT = 8;

   localparam int CFG_W        = 5;
   localparam int HITS_W       = 32;
   localparam int VICTIM_W     = 8;
   localparam int FRAMES_OUT_W = 5;
   localparam int RSP_FIELDS_W = 2 + VICTIM_W + HITS_W + FRAMES_OUT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef struct packed {
      logic capture;   // latch the incoming page reference
      logic lookup;    // compare against the table, register match results
      logic update;    // commit table changes and load the result register
   } plru_cmd_type;

endpackage
`default_nettype wire

>>> src/plru_ctrl.sv
// sequencer for the lru block: capture, lookup, update and result handshake
`timescale 1ns / 1ps
`default_nettype none
module plru_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output plru_pkg::plru_cmd_type cmd
);
   import plru_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold here until the result register can take a new transfer
            if (rsp_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> src/plru_dpath.sv
// lru datapath: page table, recency ranks, occupancy, hit counter and result register
`timescale 1ns / 1ps
`default_nettype none
module plru_dpath #(
   parameter int FRAMES    = plru_pkg::FRAMES_DEFAULT,
   parameter int PAGE_BITS = plru_pkg::PAGE_BITS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  plru_pkg::plru_cmd_type           cmd,
   input  wire [PAGE_BITS-1:0]              req_page,
   input  wire                              csr_wr_en,
   input  wire [plru_pkg::CFG_W-1:0]        csr_wr_data,
   output logic [plru_pkg::RSP_DATA_W-1:0]  rsp_data
);
   import plru_pkg::*;

   localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int OCC_W  = $clog2(FRAMES + 1);
   localparam int LIM_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;
   localparam int COPY_W = (PAGE_BITS < VICTIM_W) ? PAGE_BITS : VICTIM_W;

   logic [PAGE_BITS-1:0]  page_tbl_ff [FRAMES];
   logic [PAGE_BITS-1:0]  page_tbl_in [FRAMES];
   logic [FRAMES-1:0]     page_we;
   logic [RANK_W-1:0]     rank_ff [FRAMES];
   logic [RANK_W-1:0]     rank_in [FRAMES];
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [HITS_W-1:0]     hit_total_ff, hit_total_in;
   logic [CFG_W-1:0]      cfg_ff;

   logic [PAGE_BITS-1:0]  page_ff;
   logic [FRAMES-1:0]     match_ff, match_in;
   logic [FRAMES-1:0]     lru_ff, lru_in;
   logic                  hit_ff;
   logic [RANK_W-1:0]     pivot_ff, pivot_in;
   logic [PAGE_BITS-1:0]  victim_ff, victim_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [FRAMES-1:0]     occupied;
   logic [LIM_W-1:0]      cfg_ext, limit;
   logic                  full, evict;
   logic [RANK_W-1:0]     top_rank;
   logic [VICTIM_W-1:0]   victim_out;

   // lookup: every occupied frame compares at once, ranks pick the lru frame
   always_comb begin
      pivot_in  = '0;
      victim_in = '0;
      for (int i = 0; i < FRAMES; i++) begin
         occupied[i] = (OCC_W'(i) < occ_ff);
         match_in[i] = occupied[i] && (page_tbl_ff[i] == page_ff);
         lru_in[i]   = occupied[i] && (rank_ff[i] == '0);
         pivot_in    = pivot_in | (match_in[i] ? rank_ff[i] : '0);
         victim_in   = victim_in | (lru_in[i] ? page_tbl_ff[i] : '0);
      end
   end

   // a zero limit acts as one frame, a limit above the table acts as the table
   always_comb begin
      cfg_ext = LIM_W'(cfg_ff);
      if (cfg_ext == '0) begin
         limit = LIM_W'(1);
      end else if (cfg_ext > LIM_W'(FRAMES)) begin
         limit = LIM_W'(FRAMES);
      end else begin
         limit = cfg_ext;
      end
   end

   assign full     = !(LIM_W'(occ_ff) < limit);
   assign evict    = !hit_ff && full;
   assign top_rank = RANK_W'(occ_ff - OCC_W'(1));

   always_comb begin
      occ_in       = occ_ff;
      hit_total_in = hit_total_ff;
      for (int i = 0; i < FRAMES; i++) begin
         rank_in[i]     = rank_ff[i];
         page_tbl_in[i] = page_ff;
         page_we[i]     = 1'b0;
      end
      if (hit_ff) begin
         if (!(&hit_total_ff)) begin
            hit_total_in = hit_total_ff + HITS_W'(1);
         end
         for (int i = 0; i < FRAMES; i++) begin
            if (match_ff[i]) begin
               rank_in[i] = top_rank;
            end else if (occupied[i] && (rank_ff[i] > pivot_ff)) begin
               rank_in[i] = rank_ff[i] - RANK_W'(1);
            end
         end
      end else if (!full) begin
         occ_in = occ_ff + OCC_W'(1);
         for (int i = 0; i < FRAMES; i++) begin
            if (occ_ff == OCC_W'(i)) begin
               page_we[i] = 1'b1;
               rank_in[i] = RANK_W'(occ_ff);
            end
         end
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            if (lru_ff[i]) begin
               page_we[i] = 1'b1;
               rank_in[i] = top_rank;
            end else if (occupied[i] && (rank_ff[i] != '0)) begin
               rank_in[i] = rank_ff[i] - RANK_W'(1);
            end
         end
      end
   end

   always_comb begin
      victim_out  = evict ? VICTIM_W'(victim_ff[COPY_W-1:0]) : '0;
      rsp_data_in = '0;
      rsp_data_in[RSP_FIELDS_W-1:0] = {FRAMES_OUT_W'(occ_in), hit_total_in, victim_out,
                                       evict, hit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         hit_total_ff <= '0;
         cfg_ff       <= CFG_RESET;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (cmd.update) begin
            occ_ff       <= occ_in;
            hit_total_ff <= hit_total_in;
            for (int i = 0; i < FRAMES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
         end
      end
   end

   // page table has no reset: only occupied frames are ever looked at
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (page_we[i]) begin
               page_tbl_ff[i] <= page_tbl_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff <= req_page;
      end
      if (cmd.lookup) begin
         match_ff  <= match_in;
         lru_ff    <= lru_in;
         hit_ff    <= |match_in;
         pivot_ff  <= pivot_in;
         victim_ff <= victim_in;
      end
      if (cmd.update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

>>> src/page_replace_lru.sv
// top level of the lru page replacement block
// Usage:
//   req_ channel carries one page reference per transfer (tdata low bits).
//   rsp_ channel returns exactly one result per reference: hit, evicted,
//   victim page, saturating hit count and frames in use after the access.
//   csr_wr_en/csr_wr_data write the frame limit; write only while idle.
// Timing:
//   a reference is captured in IDLE, compared against all frames in the
//   next cycle (LOOKUP), and committed with its result loaded in UPDATE,
//   which waits while the output register still holds a result. One
//   reference is in flight at a time: the next is accepted only after
//   the capture, lookup and update steps of the sequencer are done.
// Reset: clears occupancy, ranks and hit count and sets the
//   frame limit to 16; the block is ready as soon as reset drops.
// Stall: a result not yet taken stays in the output register; the next
//   reference is still accepted and looked up, then waits before its
//   commit until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module page_replace_lru #(
   parameter int FRAMES    = plru_pkg::FRAMES_DEFAULT,
   parameter int PAGE_BITS = plru_pkg::PAGE_BITS_DEFAULT
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_tvalid,
   output logic                                      req_tready,
   // page_number
   input  wire [((PAGE_BITS + 7) / 8) * 8 - 1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire                                       rsp_tready,
   // hit, evicted, victim_page, hits_so_far, frames_used
   output logic [plru_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire                                       csr_wr_en,
   input  wire [plru_pkg::CFG_W-1:0]                 csr_wr_data
);
   import plru_pkg::*;

   plru_cmd_type cmd;

   plru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   plru_dpath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_page    (req_tdata[PAGE_BITS-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_tdata)
   );

   // only one reference in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("reference accepted while another is in flight");

   a_hit_xor_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result reports both hit and eviction");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[9:2] == 8'd0)
      else $error("victim page nonzero without eviction");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (FRAMES > 31) || (32'(rsp_tdata[46:42]) <= 32'(FRAMES)))
      else $error("frames used exceeds table size");

endmodule
`default_nettype wire

>>> tb/sv/page_replace_lru_tb.sv
// self-checking testbench for the lru page replacement block
`timescale 1ns / 1ps
module page_replace_lru_tb;
   import plru_pkg::*;

   localparam int NUM_FRAMES  = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 104;

   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic [7:0]  victim;
      logic [31:0] hits;
      logic [4:0]  used;
   } lru_result_type;

   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_type;

   class lru_scoreboard;
      logic [7:0]  page_tbl [NUM_FRAMES];
      logic [3:0]  rank_tbl [NUM_FRAMES];
      logic [4:0]  occ;
      logic [31:0] hit_count;
      logic [4:0]  limit_reg;
      lru_result_type expected_q [$];
      int          errors;
      int          refs;
      int          hits_seen;
      int          evictions;

      function new();
         for (int i = 0; i < NUM_FRAMES; i++) begin
            page_tbl[i] = '0;
            rank_tbl[i] = '0;
         end
         occ       = '0;
         hit_count = '0;
         limit_reg = CFG_RESET;
         errors    = 0;
         refs      = 0;
         hits_seen = 0;
         evictions = 0;
      endfunction

      function void set_limit(logic [4:0] value);
         limit_reg = value;
      endfunction

      // every occupied frame ranked above pivot moves one step toward least recent
      function void demote_above(logic [3:0] pivot);
         for (int i = 0; i < occ; i++)
            if (rank_tbl[i] > pivot) rank_tbl[i] = rank_tbl[i] - 4'd1;
      endfunction

      function void note_page(logic [7:0] page);
         lru_result_type r;
         int          lim;
         int          slot;
         bit          found;
         r     = '0;
         slot  = 0;
         found = 0;
         lim   = (limit_reg == 0) ? 1 : (limit_reg > NUM_FRAMES) ? NUM_FRAMES : limit_reg;
         for (int i = 0; i < occ; i++)
            if (!found && page_tbl[i] == page) begin
               found = 1;
               slot  = i;
            end
         if (found) begin
            r.hit = 1'b1;
            if (hit_count != '1) hit_count = hit_count + 32'd1;
            demote_above(rank_tbl[slot]);
            rank_tbl[slot] = 4'(occ - 1);
         end else if (occ < lim) begin
            page_tbl[occ] = page;
            rank_tbl[occ] = occ[3:0];
            occ = occ + 5'd1;
         end else begin
            // least recent frame, lowest index first
            for (int i = occ - 1; i >= 0; i--)
               if (rank_tbl[i] == 0) slot = i;
            r.evicted = 1'b1;
            r.victim  = page_tbl[slot];
            demote_above(4'd0);
            page_tbl[slot] = page;
            rank_tbl[slot] = 4'(occ - 1);
         end
         r.hits = hit_count;
         r.used = occ;
         expected_q.push_back(r);
         refs++;
         hits_seen += r.hit;
         evictions += r.evicted;
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         lru_result_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no reference outstanding: tdata %h", d);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare("hit", want.hit, d[0]);
         compare("evicted", want.evicted, d[1]);
         compare("victim_page", want.victim, d[9:2]);
         compare("hits_so_far", want.hits, d[41:10]);
         compare("frames_used", want.used, d[46:42]);
      endfunction

      function void close_out();
         if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            errors++;
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;   // page_number
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // hit, evicted, victim_page, hits_so_far, frames_used
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   lru_scoreboard sb = new();
   int            limits_written = 0;
   int            cycles = 0;
   int            rx_cycles = 0;
   int            hold_left = 0;
   bit            held_once = 0;
   rx_style_type  rx_style = RX_STEADY;

   page_replace_lru dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_limit(csr_wr_data);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_page(req_tdata);
      end
   end

   // receiver: switches among random stall styles, one long hold-off mid-run
   always @(posedge clock) begin
      rx_cycles++;
      if (rx_cycles % 50 == 0) rx_style = rx_style_type'($urandom_range(0, 3));
      if (hold_left == 0 && !held_once && sb.refs >= 400) begin
         held_once = 1;
         hold_left = 120;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   task automatic write_limit(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limits_written++;
   endtask

   task automatic send_page(input logic [7:0] page);
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop offering, wait for every outstanding result, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      // first let the last transfer reach the scoreboard
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] lim, input int count);
      int   eff;
      int   pool;
      int   burst;
      int   sent;
      bit   gapless;
      logic [7:0] base;
      logic [7:0] page;
      write_limit(lim);
      eff     = (lim == 0) ? 1 : (lim > NUM_FRAMES) ? NUM_FRAMES : lim;
      pool    = eff + eff / 2 + 2;
      base    = 8'($urandom);
      gapless = ($urandom_range(0, 3) == 0);
      sent    = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < count; k++) begin
            // mostly a small working set so hits and evictions both occur
            if ($urandom_range(0, 3) == 0) page = 8'($urandom);
            else page = base + 8'($urandom_range(0, pool - 1));
            send_page(page);
            sent++;
         end
         if (!gapless && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
      end
      settle();
   endtask

   initial begin
      int lim_plan [11];
      lim_plan = '{4, 7, 12, 16, 31, 3, 0, 1, 17, -1, -1};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero limit acts as a single frame: hit, then evictions of the one page
      write_limit(5'd0);
      send_page(8'h00);
      send_page(8'h00);
      send_page(8'hFF);
      send_page(8'hFF);
      send_page(8'h03);
      settle();
      write_limit(5'd1);
      send_page(8'h03);
      send_page(8'h55);
      settle();
      write_limit(5'd2);
      send_page(8'hAA);
      send_page(8'h55);
      send_page(8'h0F);
      send_page(8'h55);
      settle();
      // limit above the table size acts as full size
      write_limit(5'd31);
      send_page(8'hF0);
      send_page(8'h0F);
      send_page(8'h80);
      send_page(8'h01);
      settle();

      // later phases raise the limit and also lower it below occupancy
      foreach (lim_plan[p])
         run_phase((lim_plan[p] < 0) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(lim_plan[p]),
                   PHASE_ITEMS);

      sb.close_out();
      $display("run covered %0d page references: %0d hits, %0d evictions, %0d limit writes",
               sb.refs, sb.hits_seen, sb.evictions, limits_written);
      $display("receiver long hold-off with input backpressure exercised: %0d", held_once);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
